// File: design/gbfs_pkg.sv
// Shared types, constants and sequencer states of the greedy best-first search block.
package gbfs_pkg;

  localparam int NODES      = 32;
  localparam int NODE_W     = 5;
  localparam int HEUR_W     = 16;
  localparam int FR_DEPTH   = 256;
  localparam int FR_AW      = $clog2(FR_DEPTH);
  localparam int FR_CW      = $clog2(FR_DEPTH + 1);
  localparam int LOG_DEPTH  = 256;
  localparam int LOG_AW     = $clog2(LOG_DEPTH);
  localparam int LOG_CW     = $clog2(LOG_DEPTH + 1);
  localparam int DEPTH_W    = $clog2(NODES + 1);

  typedef enum logic [1:0] {
    ST_PATH     = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_UNREACH  = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_e;

  typedef enum logic [0:0] {
    OP_LOAD   = 1'b0,
    OP_SEARCH = 1'b1
  } op_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_START,
    S_INS_CHK,
    S_INS_CMP,
    S_INS_WR,
    S_POP,
    S_POP2,
    S_ROW,
    S_SCAN,
    S_SHEUR,
    S_SNEXT,
    S_PATH,
    S_PATH2,
    S_OUT_RD,
    S_OUT_LD,
    S_OUT_WAIT
  } state_e;

  typedef struct packed {
    logic [NODE_W-1:0] node;
    logic [HEUR_W-1:0] heur;
    logic [LOG_AW-1:0] link;
  } fr_entry_t;

  typedef struct packed {
    logic [NODE_W-1:0] node;
    logic [LOG_AW-1:0] parent;
  } log_entry_t;

  typedef struct packed {
    logic              ld_we;
    logic [NODE_W-1:0] ld_addr;
    logic [NODES-1:0]  ld_row;
    logic [HEUR_W-1:0] ld_heur;
    logic [NODE_W-1:0] adj_raddr;
    logic [NODE_W-1:0] heur_raddr;
  } graph_req_t;

  typedef struct packed {
    logic [NODES-1:0]  adj_rdata;
    logic [HEUR_W-1:0] heur_rdata;
  } graph_rsp_t;

  typedef struct packed {
    logic              fr_we;
    logic [FR_AW-1:0]  fr_waddr;
    fr_entry_t         fr_wdata;
    logic [FR_AW-1:0]  fr_raddr;
    logic              log_we;
    logic [LOG_AW-1:0] log_waddr;
    log_entry_t        log_wdata;
    logic [LOG_AW-1:0] log_raddr;
    logic              stk_we;
    logic [NODE_W-1:0] stk_waddr;
    logic [NODE_W-1:0] stk_wdata;
    logic [NODE_W-1:0] stk_raddr;
  } store_req_t;

  typedef struct packed {
    fr_entry_t         fr_rdata;
    log_entry_t        log_rdata;
    logic [NODE_W-1:0] stk_rdata;
  } store_rsp_t;

endpackage

// File: design/greedy_best_first_search.sv
// Greedy best-first search: a small sequencer over graph and frontier memories.
// A load item is written straight into the graph tables. A search item runs a
// sequencer that does one memory read per step: a pop, then an expansion that
// fetches the row and scans it node by node, and for each new neighbor reads
// its heuristic and does a sorted insert. An insert checks the frontier count,
// then moves every frontier entry with a heuristic not below the new one back
// by one place, one at a time through the single frontier read port. Path
// recovery follows the log node by node into the path stack, and each result
// is read back from the stack in turn; input is not accepted until the last
// result is taken.
module greedy_best_first_search (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [4:0] node_index, [36:5] neighbor_mask, [52:37] heuristic_value,
  // [57:53] start_node, [62:58] goal_node, [63] zero
  input  logic [63:0] s_axis_tdata,
  // [0] op
  input  logic [0:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [4:0] path_node, [7:5] zero
  output logic [7:0]  m_axis_tdata,
  // [1:0] status
  output logic [1:0]  m_axis_tuser,
  output logic        m_axis_tlast
);

  localparam int NW = gbfs_pkg::NODE_W;

  gbfs_pkg::state_e state_q, state_d, ret_q, ret_d;

  logic [NW-1:0]                 goal_q, goal_d;
  logic [gbfs_pkg::NODES-1:0]    visited_q, visited_d;
  logic [gbfs_pkg::NODES-1:0]    row_q, row_d;
  logic [gbfs_pkg::FR_CW-1:0]    fr_cnt_q, fr_cnt_d;
  logic [gbfs_pkg::FR_AW-1:0]    head_q, head_d;
  logic [gbfs_pkg::FR_CW-1:0]    ins_i_q, ins_i_d;
  gbfs_pkg::fr_entry_t           ins_q, ins_d;
  logic [gbfs_pkg::LOG_CW-1:0]   log_cnt_q, log_cnt_d;
  logic [gbfs_pkg::LOG_AW-1:0]   here_q, here_d;
  logic [gbfs_pkg::LOG_AW-1:0]   link_q, link_d;
  logic [gbfs_pkg::DEPTH_W-1:0]  depth_q, depth_d;
  logic [NW-1:0]                 scan_q, scan_d;
  logic                          out_valid_q, out_valid_d;
  logic [NW-1:0]                 out_node_q, out_node_d;
  gbfs_pkg::status_e             out_status_q, out_status_d;
  logic                          out_last_q, out_last_d;

  gbfs_pkg::graph_req_t graph_req;
  gbfs_pkg::graph_rsp_t graph_rsp;
  gbfs_pkg::store_req_t store_req;
  gbfs_pkg::store_rsp_t store_rsp;

  logic          in_acc;
  logic [NW-1:0] in_idx, in_start, in_goal;
  logic          in_search;

  assign in_idx    = s_axis_tdata[4:0];
  assign in_start  = s_axis_tdata[57:53];
  assign in_goal   = s_axis_tdata[62:58];
  assign in_search = (s_axis_tuser[0] == gbfs_pkg::OP_SEARCH);
  assign in_acc    = s_axis_tvalid && s_axis_tready;

  gbfs_graph u_graph (
    .clk_i (clk_i),
    .req_i (graph_req),
    .rsp_o (graph_rsp)
  );

  gbfs_store u_store (
    .clk_i (clk_i),
    .req_i (store_req),
    .rsp_o (store_rsp)
  );

  // Next state and register updates.
  always_comb begin
    state_d      = state_q;
    ret_d        = ret_q;
    goal_d       = goal_q;
    visited_d    = visited_q;
    row_d        = row_q;
    fr_cnt_d     = fr_cnt_q;
    head_d       = head_q;
    ins_i_d      = ins_i_q;
    ins_d        = ins_q;
    log_cnt_d    = log_cnt_q;
    here_d       = here_q;
    link_d       = link_q;
    depth_d      = depth_q;
    scan_d       = scan_q;
    out_valid_d  = out_valid_q;
    out_node_d   = out_node_q;
    out_status_d = out_status_q;
    out_last_d   = out_last_q;
    case (state_q)
      gbfs_pkg::S_IDLE: begin
        if (in_acc && in_search) begin
          goal_d    = in_goal;
          visited_d = '0;
          fr_cnt_d  = '0;
          head_d    = '0;
          log_cnt_d = '0;
          ins_d.node = in_start;
          state_d   = gbfs_pkg::S_START;
        end
      end
      gbfs_pkg::S_START: begin
        ins_d.heur = graph_rsp.heur_rdata;
        ins_d.link = '0;
        ret_d      = gbfs_pkg::S_POP;
        state_d    = gbfs_pkg::S_INS_CHK;
      end
      gbfs_pkg::S_INS_CHK: begin
        if (fr_cnt_q >= gbfs_pkg::FR_CW'(gbfs_pkg::FR_DEPTH)) begin
          out_valid_d  = 1'b1;
          out_node_d   = '0;
          out_status_d = gbfs_pkg::ST_OVERFLOW;
          out_last_d   = 1'b1;
          depth_d      = '0;
          state_d      = gbfs_pkg::S_OUT_WAIT;
        end else if (fr_cnt_q == '0) begin
          fr_cnt_d = fr_cnt_q + 1'b1;
          state_d  = ret_q;
        end else begin
          ins_i_d = fr_cnt_q;
          state_d = gbfs_pkg::S_INS_CMP;
        end
      end
      gbfs_pkg::S_INS_CMP: begin
        // Entries not below the new heuristic move back by one place.
        if (ins_q.heur <= store_rsp.fr_rdata.heur) begin
          ins_i_d = ins_i_q - 1'b1;
          if (ins_i_q == gbfs_pkg::FR_CW'(1)) begin
            state_d = gbfs_pkg::S_INS_WR;
          end
        end else begin
          fr_cnt_d = fr_cnt_q + 1'b1;
          state_d  = ret_q;
        end
      end
      gbfs_pkg::S_INS_WR: begin
        fr_cnt_d = fr_cnt_q + 1'b1;
        state_d  = ret_q;
      end
      gbfs_pkg::S_POP: begin
        if (fr_cnt_q == '0) begin
          out_valid_d  = 1'b1;
          out_node_d   = '0;
          out_status_d = gbfs_pkg::ST_UNREACH;
          out_last_d   = 1'b1;
          depth_d      = '0;
          state_d      = gbfs_pkg::S_OUT_WAIT;
        end else begin
          state_d = gbfs_pkg::S_POP2;
        end
      end
      gbfs_pkg::S_POP2: begin
        head_d    = head_q + 1'b1;
        fr_cnt_d  = fr_cnt_q - 1'b1;
        visited_d = visited_q | (gbfs_pkg::NODES'(1) << store_rsp.fr_rdata.node);
        if (store_rsp.fr_rdata.node == goal_q) begin
          if (log_cnt_q == '0) begin
            out_valid_d  = 1'b1;
            out_node_d   = '0;
            out_status_d = gbfs_pkg::ST_EMPTY;
            out_last_d   = 1'b1;
            depth_d      = '0;
            state_d      = gbfs_pkg::S_OUT_WAIT;
          end else begin
            depth_d = gbfs_pkg::DEPTH_W'(1);
            link_d  = store_rsp.fr_rdata.link;
            state_d = gbfs_pkg::S_PATH;
          end
        end else if (log_cnt_q >= gbfs_pkg::LOG_CW'(gbfs_pkg::LOG_DEPTH)) begin
          out_valid_d  = 1'b1;
          out_node_d   = '0;
          out_status_d = gbfs_pkg::ST_OVERFLOW;
          out_last_d   = 1'b1;
          depth_d      = '0;
          state_d      = gbfs_pkg::S_OUT_WAIT;
        end else begin
          here_d    = log_cnt_q[gbfs_pkg::LOG_AW-1:0];
          log_cnt_d = log_cnt_q + 1'b1;
          state_d   = gbfs_pkg::S_ROW;
        end
      end
      gbfs_pkg::S_ROW: begin
        row_d   = graph_rsp.adj_rdata;
        scan_d  = '0;
        state_d = gbfs_pkg::S_SCAN;
      end
      gbfs_pkg::S_SCAN: begin
        if (row_q[scan_q] && !visited_q[scan_q]) begin
          state_d = gbfs_pkg::S_SHEUR;
        end else if (scan_q == NW'(gbfs_pkg::NODES - 1)) begin
          state_d = gbfs_pkg::S_POP;
        end else begin
          scan_d = scan_q + 1'b1;
        end
      end
      gbfs_pkg::S_SHEUR: begin
        ins_d.node = scan_q;
        ins_d.heur = graph_rsp.heur_rdata;
        ins_d.link = here_q;
        ret_d      = gbfs_pkg::S_SNEXT;
        state_d    = gbfs_pkg::S_INS_CHK;
      end
      gbfs_pkg::S_SNEXT: begin
        if (scan_q == NW'(gbfs_pkg::NODES - 1)) begin
          state_d = gbfs_pkg::S_POP;
        end else begin
          scan_d  = scan_q + 1'b1;
          state_d = gbfs_pkg::S_SCAN;
        end
      end
      gbfs_pkg::S_PATH: begin
        if (link_q != '0 && gbfs_pkg::LOG_CW'(link_q) < log_cnt_q &&
            depth_q < gbfs_pkg::DEPTH_W'(gbfs_pkg::NODES)) begin
          state_d = gbfs_pkg::S_PATH2;
        end else begin
          state_d = gbfs_pkg::S_OUT_RD;
        end
      end
      gbfs_pkg::S_PATH2: begin
        depth_d = depth_q + 1'b1;
        link_d  = store_rsp.log_rdata.parent;
        state_d = gbfs_pkg::S_PATH;
      end
      gbfs_pkg::S_OUT_RD: begin
        state_d = gbfs_pkg::S_OUT_LD;
      end
      gbfs_pkg::S_OUT_LD: begin
        out_valid_d  = 1'b1;
        out_node_d   = store_rsp.stk_rdata;
        out_status_d = gbfs_pkg::ST_PATH;
        out_last_d   = (depth_q == gbfs_pkg::DEPTH_W'(1));
        depth_d      = depth_q - 1'b1;
        state_d      = gbfs_pkg::S_OUT_WAIT;
      end
      gbfs_pkg::S_OUT_WAIT: begin
        if (m_axis_tready) begin
          out_valid_d = 1'b0;
          state_d     = (depth_q == '0) ? gbfs_pkg::S_IDLE : gbfs_pkg::S_OUT_RD;
        end
      end
      default: begin
        state_d = gbfs_pkg::S_IDLE;
      end
    endcase
  end

  // Memory ports and handshake outputs.
  always_comb begin
    s_axis_tready        = (state_q == gbfs_pkg::S_IDLE);
    graph_req            = '0;
    graph_req.ld_we      = in_acc && !in_search;
    graph_req.ld_addr    = in_idx;
    graph_req.ld_row     = s_axis_tdata[36:5];
    graph_req.ld_heur    = s_axis_tdata[52:37];
    graph_req.heur_raddr = scan_q;
    graph_req.adj_raddr  = store_rsp.fr_rdata.node;
    store_req            = '0;
    store_req.fr_raddr   = head_q;
    store_req.log_raddr  = link_q;
    store_req.stk_raddr  = NW'(depth_q - 1'b1);
    case (state_q)
      gbfs_pkg::S_IDLE: begin
        graph_req.heur_raddr = in_start;
      end
      gbfs_pkg::S_INS_CHK: begin
        if (fr_cnt_q == '0) begin
          store_req.fr_we    = 1'b1;
          store_req.fr_waddr = head_q;
          store_req.fr_wdata = ins_q;
        end else begin
          store_req.fr_raddr = head_q + gbfs_pkg::FR_AW'(fr_cnt_q - 1'b1);
        end
      end
      gbfs_pkg::S_INS_CMP: begin
        store_req.fr_we    = 1'b1;
        store_req.fr_waddr = head_q + gbfs_pkg::FR_AW'(ins_i_q);
        if (ins_q.heur <= store_rsp.fr_rdata.heur) begin
          store_req.fr_wdata = store_rsp.fr_rdata;
          store_req.fr_raddr = head_q + gbfs_pkg::FR_AW'(ins_i_q - 2'd2);
        end else begin
          store_req.fr_wdata = ins_q;
        end
      end
      gbfs_pkg::S_INS_WR: begin
        store_req.fr_we    = 1'b1;
        store_req.fr_waddr = head_q;
        store_req.fr_wdata = ins_q;
      end
      gbfs_pkg::S_POP2: begin
        if (store_rsp.fr_rdata.node == goal_q) begin
          store_req.stk_we    = 1'b1;
          store_req.stk_waddr = '0;
          store_req.stk_wdata = store_rsp.fr_rdata.node;
        end else begin
          store_req.log_we           = 1'b1;
          store_req.log_waddr        = log_cnt_q[gbfs_pkg::LOG_AW-1:0];
          store_req.log_wdata.node   = store_rsp.fr_rdata.node;
          store_req.log_wdata.parent = store_rsp.fr_rdata.link;
        end
      end
      gbfs_pkg::S_PATH2: begin
        store_req.stk_we    = 1'b1;
        store_req.stk_waddr = NW'(depth_q);
        store_req.stk_wdata = store_rsp.log_rdata.node;
      end
      default: begin
      end
    endcase
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, out_node_q};
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tlast  = out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= gbfs_pkg::S_IDLE;
      ret_q       <= gbfs_pkg::S_POP;
      visited_q   <= '0;
      fr_cnt_q    <= '0;
      head_q      <= '0;
      log_cnt_q   <= '0;
      depth_q     <= '0;
      scan_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ret_q       <= ret_d;
      visited_q   <= visited_d;
      fr_cnt_q    <= fr_cnt_d;
      head_q      <= head_d;
      log_cnt_q   <= log_cnt_d;
      depth_q     <= depth_d;
      scan_q      <= scan_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    goal_q       <= goal_d;
    row_q        <= row_d;
    ins_i_q      <= ins_i_d;
    ins_q        <= ins_d;
    here_q       <= here_d;
    link_q       <= link_d;
    out_node_q   <= out_node_d;
    out_status_q <= out_status_d;
    out_last_q   <= out_last_d;
  end

`ifndef NO_ASSERTIONS
  a_ready_excl : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !m_axis_tvalid)
    else $error("input ready while a result is pending");

  a_fr_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fr_cnt_q <= gbfs_pkg::FR_CW'(gbfs_pkg::FR_DEPTH))
    else $error("frontier count beyond depth");

  a_depth_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    depth_q <= gbfs_pkg::DEPTH_W'(gbfs_pkg::NODES))
    else $error("path depth beyond node count");

  a_status_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser != gbfs_pkg::ST_PATH) |-> m_axis_tlast)
    else $error("single-result status without last");
`endif

endmodule

// File: design/gbfs_graph.sv
// Adjacency row and heuristic tables, one write and one registered read each.
module gbfs_graph (
  input  logic                clk_i,
  input  gbfs_pkg::graph_req_t req_i,
  output gbfs_pkg::graph_rsp_t rsp_o
);

  logic [gbfs_pkg::NODES-1:0]  adj_mem  [gbfs_pkg::NODES];
  logic [gbfs_pkg::HEUR_W-1:0] heur_mem [gbfs_pkg::NODES];

  always_ff @(posedge clk_i) begin
    if (req_i.ld_we) begin
      adj_mem[req_i.ld_addr]  <= req_i.ld_row;
      heur_mem[req_i.ld_addr] <= req_i.ld_heur;
    end
    rsp_o.adj_rdata  <= adj_mem[req_i.adj_raddr];
    rsp_o.heur_rdata <= heur_mem[req_i.heur_raddr];
  end

endmodule

// File: design/gbfs_store.sv
// Frontier, expansion log and path stack memories with registered reads.
module gbfs_store (
  input  logic                clk_i,
  input  gbfs_pkg::store_req_t req_i,
  output gbfs_pkg::store_rsp_t rsp_o
);

  gbfs_pkg::fr_entry_t         fr_mem  [gbfs_pkg::FR_DEPTH];
  gbfs_pkg::log_entry_t        log_mem [gbfs_pkg::LOG_DEPTH];
  logic [gbfs_pkg::NODE_W-1:0] stk_mem [gbfs_pkg::NODES];

  always_ff @(posedge clk_i) begin
    if (req_i.fr_we) begin
      fr_mem[req_i.fr_waddr] <= req_i.fr_wdata;
    end
    if (req_i.log_we) begin
      log_mem[req_i.log_waddr] <= req_i.log_wdata;
    end
    if (req_i.stk_we) begin
      stk_mem[req_i.stk_waddr] <= req_i.stk_wdata;
    end
    rsp_o.fr_rdata  <= fr_mem[req_i.fr_raddr];
    rsp_o.log_rdata <= log_mem[req_i.log_raddr];
    rsp_o.stk_rdata <= stk_mem[req_i.stk_raddr];
  end

endmodule

// File: tb/sv/greedy_best_first_search_test.sv
// Testbench for the greedy best-first search block: predicted paths checked per item.
`timescale 1ns / 1ps

module greedy_best_first_search_test;

  localparam int WATCHDOG_LIMIT = 5000000;

  typedef struct packed {
    logic [4:0]        node;
    gbfs_pkg::status_e status;
    logic              last;
  } path_item_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;
  logic [0:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b1;
  logic [7:0]  m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;

  greedy_best_first_search dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .m_axis_tlast(m_axis_tlast)
  );

  always #10 clk_i = ~clk_i;

  // Predictor state: graph tables plus the scratch frontier and expansion log.
  logic [31:0] adj_row [gbfs_pkg::NODES];
  logic [15:0] heur_tab [gbfs_pkg::NODES];
  int          fr_node [gbfs_pkg::FR_DEPTH];
  int          fr_heur [gbfs_pkg::FR_DEPTH];
  int          fr_link [gbfs_pkg::FR_DEPTH];
  int          fr_count;
  int          log_node [gbfs_pkg::LOG_DEPTH];
  int          log_parent [gbfs_pkg::LOG_DEPTH];
  int          log_count;

  path_item_t path_expect_q[$];
  int         mismatches = 0;
  int         idle_pct = 0;
  int         stall_pct = 0;
  int         quiet_cycles = 0;

  function automatic void push_result(int node, gbfs_pkg::status_e st, logic last);
    path_item_t r;
    r.node = node[4:0];
    r.status = st;
    r.last = last;
    path_expect_q.insert(path_expect_q.size(), r);
  endfunction

  // Sorted insert; a new entry goes ahead of entries with an equal heuristic.
  function automatic bit frontier_put(int node, int h, int link);
    int pos;
    pos = 0;
    if (fr_count >= gbfs_pkg::FR_DEPTH) return 1'b0;
    while (pos < fr_count && h > fr_heur[pos]) pos++;
    for (int i = fr_count; i > pos; i--) begin
      fr_node[i] = fr_node[i-1];
      fr_heur[i] = fr_heur[i-1];
      fr_link[i] = fr_link[i-1];
    end
    fr_node[pos] = node;
    fr_heur[pos] = h;
    fr_link[pos] = link;
    fr_count++;
    return 1'b1;
  endfunction

  function automatic void predict_search(int start, int goal);
    logic [31:0] seen;
    int node, link, here, depth;
    int stack [gbfs_pkg::NODES];
    seen = '0;
    fr_count = 0;
    log_count = 0;
    void'(frontier_put(start, heur_tab[start], 0));
    forever begin
      if (fr_count == 0) begin
        push_result(0, gbfs_pkg::ST_UNREACH, 1'b1);
        return;
      end
      node = fr_node[0];
      link = fr_link[0];
      for (int i = 1; i < fr_count; i++) begin
        fr_node[i-1] = fr_node[i];
        fr_heur[i-1] = fr_heur[i];
        fr_link[i-1] = fr_link[i];
      end
      fr_count--;
      seen[node] = 1'b1;
      if (node == goal) begin
        if (log_count == 0) begin
          push_result(0, gbfs_pkg::ST_EMPTY, 1'b1);
          return;
        end
        depth = 0;
        stack[depth] = node;
        depth++;
        while (link != 0 && link < log_count && depth < gbfs_pkg::NODES) begin
          stack[depth] = log_node[link];
          depth++;
          link = log_parent[link];
        end
        for (int k = 0; k < depth; k++)
          push_result(stack[depth-1-k], gbfs_pkg::ST_PATH, k == depth - 1);
        return;
      end
      if (log_count >= gbfs_pkg::LOG_DEPTH) begin
        push_result(0, gbfs_pkg::ST_OVERFLOW, 1'b1);
        return;
      end
      here = log_count;
      log_node[here] = node;
      log_parent[here] = link;
      log_count++;
      for (int j = 0; j < gbfs_pkg::NODES; j++) begin
        if (adj_row[node][j] && !seen[j]) begin
          if (!frontier_put(j, heur_tab[j], here)) begin
            push_result(0, gbfs_pkg::ST_OVERFLOW, 1'b1);
            return;
          end
        end
      end
    end
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_item(gbfs_pkg::op_e op, int idx, logic [31:0] mask, logic [15:0] h,
                           int start, int goal);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= op;
    s_axis_tdata <= {1'b0, goal[4:0], start[4:0], h, mask, idx[4:0]};
    do @(posedge clk_i); while (!s_axis_tready);
    if (op == gbfs_pkg::OP_LOAD) begin
      adj_row[idx] = mask;
      heur_tab[idx] = h;
    end else begin
      predict_search(start, goal);
    end
    @(negedge clk_i);
  endtask

  task automatic load_node(int idx, logic [31:0] mask, logic [15:0] h);
    send_item(gbfs_pkg::OP_LOAD, idx, mask, h, $urandom_range(31), $urandom_range(31));
  endtask

  task automatic search(int start, int goal);
    send_item(gbfs_pkg::OP_SEARCH, $urandom_range(31), $urandom, 16'($urandom),
              start, goal);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (path_expect_q.size() != 0) @(negedge clk_i);
  endtask

  function automatic logic [31:0] random_row();
    case ($urandom_range(9))
      0:       return $urandom;
      1:       return '0;
      default: return $urandom & $urandom & $urandom;
    endcase
  endfunction

  // Chain graph with self-loops, an unreachable tail, ties and a dense overflow.
  task automatic test_directed();
    for (int i = 0; i < gbfs_pkg::NODES; i++)
      load_node(i, (i == gbfs_pkg::NODES - 1) ? 32'h0 : ((32'h1 << (i + 1)) | (32'h1 << i)),
                (i == 0) ? 16'hFFFF : 16'(gbfs_pkg::NODES - 1 - i));
    search(0, 31);
    search(5, 5);
    search(31, 0);
    search(3, 7);
    // Pause the sender until every path item is back.
    wait_drained();
    load_node(0, 32'hFFFF_FFFF, 16'h0000);
    for (int i = 1; i < gbfs_pkg::NODES; i++) load_node(i, 32'hFFFF_FFFF, 16'h0);
    search(1, 0);
    search(30, 2);
    load_node(4, 32'h0000_0010, 16'hFFFF);
    search(4, 9);
    wait_drained();
  endtask

  task automatic test_random(int items, int sender_idle, int receiver_stall);
    idle_pct = sender_idle;
    stall_pct = receiver_stall;
    for (int i = 0; i < gbfs_pkg::NODES; i++)
      load_node(i, random_row(), ($urandom_range(1)) ? 16'($urandom) : 16'($urandom_range(3)));
    for (int n = 0; n < items; n++) begin
      if ($urandom_range(99) < 25)
        load_node($urandom_range(31), random_row(), 16'($urandom));
      else
        search($urandom_range(31), $urandom_range(31));
    end
    wait_drained();
  endtask

  always @(negedge clk_i)
    m_axis_tready <= ($urandom_range(99) >= stall_pct);

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (path_expect_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected item: node %0d status %0d last %0d",
                   m_axis_tdata[4:0], m_axis_tuser, m_axis_tlast);
      end else begin
        path_item_t exp_item;
        exp_item = path_expect_q.pop_front();
        if (m_axis_tdata[4:0] !== exp_item.node || m_axis_tuser !== exp_item.status ||
            m_axis_tlast !== exp_item.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected node %0d status %0d last %0d, got %0d %0d %0d",
                     exp_item.node, exp_item.status, exp_item.last,
                     m_axis_tdata[4:0], m_axis_tuser, m_axis_tlast);
        end
      end
    end
  end

  // Watchdog on cycles in which neither side moves an item.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed();
    test_random(40, 0, 0);
    test_random(40, 75, 0);
    test_random(40, 0, 75);
    test_random(40, 18, 18);
    repeat (50) @(negedge clk_i);
    if (mismatches == 0 && path_expect_q.size() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

// File: greedy_best_first_search.f
design/gbfs_pkg.sv
design/gbfs_graph.sv
design/gbfs_store.sv
design/greedy_best_first_search.sv
tb/sv/greedy_best_first_search_test.sv
